>>> design/pdfu_pkg.sv
// Shared types and constants for the PDF literal string unescaper.
`default_nettype none
package pdfu_pkg;

	localparam logic [1:0] MODE_PLAIN     = 2'd0;
	localparam logic [1:0] MODE_BACKSLASH = 2'd1;
	localparam logic [1:0] MODE_OCTAL     = 2'd2;

	localparam logic [2:0] OCTAL_MAX_DIGITS = 3'd3;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_SEVEN     = 8'h37;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_R         = 8'h72;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_B         = 8'h62;
	localparam logic [7:0] CH_F         = 8'h66;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_BS        = 8'h08;
	localparam logic [7:0] CH_FF        = 8'h0C;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_last;
	} res_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] value;
		logic [1:0] digits;
	} esc_state_t;

	// Results produced by one input byte, zero to two
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage
`default_nettype wire

>>> design/pdfu_decode.sv
// Combinational escape decoder: one input byte plus current state to results and next state.
`default_nettype none
module pdfu_decode (
	input  wire logic [7:0]         in_byte,
	input  wire logic               in_last,
	input  wire pdfu_pkg::esc_state_t cur,
	output pdfu_pkg::esc_state_t    nxt,
	output pdfu_pkg::push_t         push
);

	logic [7:0] mapped;
	logic       is_mapped;
	logic       is_oct;
	logic [2:0] digit;
	logic [7:0] acc;
	logic [2:0] cnt;

	always_comb begin
		is_mapped = 1'b1;
		case (in_byte)
			pdfu_pkg::CH_LPAREN:    mapped = pdfu_pkg::CH_LPAREN;
			pdfu_pkg::CH_RPAREN:    mapped = pdfu_pkg::CH_RPAREN;
			pdfu_pkg::CH_BACKSLASH: mapped = pdfu_pkg::CH_BACKSLASH;
			pdfu_pkg::CH_N:         mapped = pdfu_pkg::CH_LF;
			pdfu_pkg::CH_R:         mapped = pdfu_pkg::CH_CR;
			pdfu_pkg::CH_T:         mapped = pdfu_pkg::CH_TAB;
			pdfu_pkg::CH_B:         mapped = pdfu_pkg::CH_BS;
			pdfu_pkg::CH_F:         mapped = pdfu_pkg::CH_FF;
			default: begin
				mapped    = in_byte;
				is_mapped = 1'b0;
			end
		endcase
	end

	assign is_oct = in_byte inside {[pdfu_pkg::CH_ZERO : pdfu_pkg::CH_SEVEN]};
	assign digit  = in_byte[2:0];
	assign acc    = {cur.value[4:0], digit};
	assign cnt    = {1'b0, cur.digits} + 3'd1;

	always_comb begin
		nxt       = '{mode: pdfu_pkg::MODE_PLAIN, value: 8'd0, digits: 2'd0};
		push      = '0;
		case (cur.mode)
			pdfu_pkg::MODE_BACKSLASH: begin
				if (!is_mapped && is_oct) begin
					if (in_last) begin
						push.n  = 2'd1;
						push.r0 = '{out_byte: {5'd0, digit}, run_last: 1'b1, string_last: 1'b1};
					end else begin
						nxt = '{mode: pdfu_pkg::MODE_OCTAL, value: {5'd0, digit}, digits: 2'd1};
					end
				end else begin
					push.n  = 2'd1;
					push.r0 = '{out_byte: mapped, run_last: 1'b1, string_last: in_last};
				end
			end
			pdfu_pkg::MODE_OCTAL: begin
				if (is_oct) begin
					if (cnt >= pdfu_pkg::OCTAL_MAX_DIGITS || in_last) begin
						push.n  = 2'd1;
						push.r0 = '{out_byte: acc, run_last: 1'b1, string_last: in_last};
					end else begin
						nxt = '{mode: pdfu_pkg::MODE_OCTAL, value: acc, digits: cnt[1:0]};
					end
				end else begin
					// Flush the run, then treat the byte as plain
					push.r0 = '{out_byte: cur.value, run_last: 1'b0, string_last: 1'b0};
					if (in_byte == pdfu_pkg::CH_BACKSLASH && !in_last) begin
						push.n          = 2'd1;
						push.r0.run_last = 1'b1;
						nxt.mode        = pdfu_pkg::MODE_BACKSLASH;
					end else begin
						push.n  = 2'd2;
						push.r1 = '{out_byte: in_byte, run_last: 1'b1, string_last: in_last};
					end
				end
			end
			default: begin
				if (in_byte == pdfu_pkg::CH_BACKSLASH && !in_last) begin
					nxt.mode = pdfu_pkg::MODE_BACKSLASH;
				end else begin
					push.n  = 2'd1;
					push.r0 = '{out_byte: in_byte, run_last: 1'b1, string_last: in_last};
				end
			end
		endcase
	end

endmodule
`default_nettype wire

>>> design/pdfu_outbuf.sv
// Two-entry result queue that feeds the output stream.
`default_nettype none
module pdfu_outbuf (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pdfu_pkg::push_t push,
	input  wire logic            pop,
	output logic [1:0]           free,
	output logic                 head_valid,
	output pdfu_pkg::res_t       head
);

	pdfu_pkg::res_t e0_q, e1_q;
	logic [1:0]     count_q;
	logic [1:0]     cnt_after;

	assign cnt_after  = count_q - {1'b0, pop};
	assign free       = 2'd2 - cnt_after;
	assign head_valid = count_q != 2'd0;
	assign head       = e0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= cnt_after + push.n;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_after == 2'd0) begin
			e0_q <= push.r0;
			e1_q <= push.r1;
		end else begin
			if (pop) begin
				e0_q <= e1_q;
			end
			if (cnt_after == 2'd1) begin
				e1_q <= push.r0;
			end
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("result queue overfilled");
	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push.n <= free) else $error("push larger than free space");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0) else $error("pop from empty queue");

endmodule
`default_nettype wire

>>> design/pdf_literal_string_unescaper_core.sv
// Top level of the PDF literal string unescaper: input stage, escape state and result queue.
//
//  channel | dir | tdata              | side bands
//  s_axis  | in  | [7:0] in_byte      | tlast = in_last
//  m_axis  | out | [7:0] out_byte     | tuser[0] = run_last, tlast = string_last
//
// One byte per cycle is taken while the result queue has room. A byte is decoded from the input
// register into the two-entry result queue, which drains one result per cycle while m_axis_tready
// is high, so a byte giving two results holds the input register until both fit. A result is
// offered on m_axis after passing the input register and the result queue. Reset clears escape
// state and queue; m_axis stalls back up through the queue into s_axis_tready.
`default_nettype none
module pdf_literal_string_unescaper_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  wire logic       s_axis_tlast,
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
	output logic [0:0]      m_axis_tuser,   // [0] run_last
	output logic            m_axis_tlast
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	pdfu_pkg::esc_state_t state_q;
	pdfu_pkg::esc_state_t state_nxt;
	pdfu_pkg::push_t      dec_push;
	pdfu_pkg::push_t      buf_push;
	pdfu_pkg::res_t       head;
	logic [1:0]           free;
	logic                 head_valid;
	logic                 pop;
	logic                 advance;

	pdfu_decode u_decode (
		.in_byte (byte_s1),
		.in_last (last_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.push    (dec_push)
	);

	assign pop     = head_valid && m_axis_tready;
	assign advance = valid_s1 && (dec_push.n <= free);

	always_comb begin
		buf_push = dec_push;
		if (!advance) begin
			buf_push.n = 2'd0;
		end
	end

	pdfu_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (buf_push),
		.pop        (pop),
		.free       (free),
		.head_valid (head_valid),
		.head       (head)
	);

	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = head_valid;
	assign m_axis_tdata  = head.out_byte;
	assign m_axis_tuser  = head.run_last;
	assign m_axis_tlast  = head.string_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '{mode: pdfu_pkg::MODE_PLAIN, value: 8'd0, digits: 2'd0};
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	a_octal_digits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == pdfu_pkg::MODE_OCTAL |-> state_q.digits == 2'd1 || state_q.digits == 2'd2)
		else $error("octal run with bad digit count");
	a_clear_acc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode != pdfu_pkg::MODE_OCTAL |-> state_q.value == 8'd0 && state_q.digits == 2'd0)
		else $error("accumulator not cleared outside octal run");
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("stalled input stage lost its byte");
	a_last_flush: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> state_q.mode == pdfu_pkg::MODE_PLAIN)
		else $error("final byte left escape pending");

endmodule
`default_nettype wire
